[rtl/core/pmiu_pkg.sv]
// Shared types, codes and helpers of the packed matrix index unit.
package pmiu_pkg;

  localparam int unsigned MAX_DIM   = 1024;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned OFS_W     = 21;
  localparam int unsigned PROD_W    = OFS_W + 1;
  localparam int unsigned FMT_W     = 3;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 48;

  // storage formats
  localparam logic [FMT_W-1:0] FMT_FULL    = 3'd0;
  localparam logic [FMT_W-1:0] FMT_BANDED  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_UPPER   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_LOWER   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_SYM     = 3'd4;
  localparam logic [FMT_W-1:0] FMT_DIAG    = 3'd5;
  localparam logic [FMT_W-1:0] FMT_SYMBAND = 3'd6;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_FORMAT     = 3'd0;
  localparam logic [IDX_W-1:0] REG_TOTAL_ROWS = 3'd1;
  localparam logic [IDX_W-1:0] REG_TOTAL_COLS = 3'd2;
  localparam logic [IDX_W-1:0] REG_SUB_DIAGS  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SUPER_DIAGS = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRANSPOSED = 3'd5;

  typedef struct packed {
    logic [FMT_W-1:0] format;
    logic [DIM_W-1:0] total_rows;
    logic [DIM_W-1:0] total_cols;
    logic [DIM_W-1:0] sub_diags;
    logic [DIM_W-1:0] super_diags;
    logic             transposed_walk;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] next_row;
    logic [POS_W-1:0] next_col;
    logic             walk_end;
    logic             walk_defined;
  } walk_t;

  // stage 1 -> stage 2: multiplier operands plus side data
  typedef struct packed {
    logic [POS_W-1:0]  mul_a;
    logic [PROD_W-1:0] mul_b;
    logic              half;
    logic [OFS_W-1:0]  addend;
    logic              stored;
    walk_t             walk;
  } op_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              half;
    logic [OFS_W-1:0]  addend;
    logic              stored;
    walk_t             walk;
  } prod_t;

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic             stored;
    walk_t            walk;
  } res_t;

  // MAX_DIM diagonals means all of them: rows-1, or 0 for an empty matrix
  function automatic logic [DIM_W-1:0] diag_count(input logic [DIM_W-1:0] rows,
                                                  input logic [DIM_W-1:0] d);
    if (d != DIM_W'(MAX_DIM)) return d;
    return (rows != '0) ? rows - DIM_W'(1) : '0;
  endfunction

endpackage

[rtl/core/pmiu_prep.sv]
// Stage 1: format decode, multiplier operands, stored flag and walk step.
module pmiu_prep (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pmiu_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pmiu_pkg::POS_W-1:0]   row_pos_i,
  input  logic [pmiu_pkg::POS_W-1:0]   col_pos_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pmiu_pkg::op_t                op_o
);

  localparam int unsigned DW = pmiu_pkg::DIM_W;

  logic          valid_q;
  pmiu_pkg::op_t op_q, op_d;

  // one step of the upper triangular walk; returns {end, row, col}
  function automatic logic [2*DW:0] upper_step(input logic [DW-1:0] lim,
                                               input logic [DW-1:0] rr_i,
                                               input logic [DW-1:0] cc_i);
    logic [DW-1:0] rr;
    logic [DW-1:0] cc;
    rr = rr_i;
    cc = cc_i;
    if (rr <= cc) rr = rr + DW'(1);
    if (rr > cc) begin
      cc = cc + DW'(1);
      rr = '0;
    end
    return {(cc >= lim), rr, cc};
  endfunction

  always_comb begin
    logic [DW-1:0]              r_x, c_x, rows, cols, kl, ku, k, nr, nc;
    logic [pmiu_pkg::POS_W-1:0] a, b, diff;
    logic [2*DW:0]              uw;
    logic                       st, wend, def;

    r_x  = DW'(row_pos_i);
    c_x  = DW'(col_pos_i);
    rows = cfg_i.total_rows;
    cols = cfg_i.total_cols;
    a    = (row_pos_i <= col_pos_i) ? row_pos_i : col_pos_i;
    b    = (row_pos_i <= col_pos_i) ? col_pos_i : row_pos_i;
    diff = b - a;
    kl   = pmiu_pkg::diag_count(rows, cfg_i.sub_diags);
    ku   = pmiu_pkg::diag_count(rows, cfg_i.super_diags);
    k    = ku;
    nr   = '0;
    nc   = '0;
    uw   = '0;
    st   = 1'b0;
    wend = 1'b0;
    def  = 1'b1;

    op_d        = '0;
    op_d.mul_a  = col_pos_i;

    case (cfg_i.format)
      pmiu_pkg::FMT_FULL, pmiu_pkg::FMT_SYM: begin
        if (cfg_i.format == pmiu_pkg::FMT_FULL) begin
          op_d.mul_b  = pmiu_pkg::PROD_W'(rows);
          op_d.addend = pmiu_pkg::OFS_W'(row_pos_i);
        end else begin
          op_d.mul_a  = b;
          op_d.mul_b  = pmiu_pkg::PROD_W'(b) + pmiu_pkg::PROD_W'(1);
          op_d.half   = 1'b1;
          op_d.addend = pmiu_pkg::OFS_W'(a);
        end
        st = 1'b1;
        nr = (r_x < rows) ? r_x + DW'(1) : r_x;
        nc = c_x;
        if (nr >= rows) begin
          nr = '0;
          nc = c_x + DW'(1);
        end
        wend = (nc >= cols);
      end
      pmiu_pkg::FMT_BANDED: begin
        st = (col_pos_i <= row_pos_i) ? (DW'(diff) <= kl) : (DW'(diff) <= ku);
        op_d.mul_b  = pmiu_pkg::PROD_W'(kl) + pmiu_pkg::PROD_W'(ku)
                      + pmiu_pkg::PROD_W'(1);
        op_d.addend = pmiu_pkg::OFS_W'(ku) + pmiu_pkg::OFS_W'(row_pos_i)
                      - pmiu_pkg::OFS_W'(col_pos_i);
        def = 1'b0;
      end
      pmiu_pkg::FMT_UPPER: begin
        st          = (row_pos_i <= col_pos_i);
        op_d.mul_b  = pmiu_pkg::PROD_W'(col_pos_i) + pmiu_pkg::PROD_W'(1);
        op_d.half   = 1'b1;
        op_d.addend = pmiu_pkg::OFS_W'(row_pos_i);
        uw   = upper_step(cols, r_x, c_x);
        nr   = uw[2*DW-1:DW];
        nc   = uw[DW-1:0];
        wend = uw[2*DW];
      end
      pmiu_pkg::FMT_LOWER: begin
        st = (row_pos_i >= col_pos_i);
        // (2C - c - 1) may go negative; wraps mod 2^22, product stays exact
        op_d.mul_b  = pmiu_pkg::PROD_W'({cols, 1'b0}) - pmiu_pkg::PROD_W'(col_pos_i)
                      - pmiu_pkg::PROD_W'(1);
        op_d.half   = 1'b1;
        op_d.addend = pmiu_pkg::OFS_W'(row_pos_i);
        if (cfg_i.transposed_walk) begin
          // upper walk on the swapped position, swapped back
          uw   = upper_step(rows, c_x, r_x);
          nr   = uw[DW-1:0];
          nc   = uw[2*DW-1:DW];
          wend = uw[2*DW];
        end else begin
          nr = (r_x < rows) ? r_x + DW'(1) : r_x;
          nc = c_x;
          if (nr >= rows) begin
            nc = c_x + DW'(1);
            nr = nc;
          end
          wend = (nc >= cols);
        end
      end
      pmiu_pkg::FMT_DIAG: begin
        st          = (row_pos_i == col_pos_i);
        op_d.mul_b  = '0;
        op_d.addend = pmiu_pkg::OFS_W'(row_pos_i);
        nr = r_x;
        nc = c_x;
        if (r_x < rows) begin
          nr = r_x + DW'(1);
          nc = c_x + DW'(1);
        end
        wend = (nr >= rows);
      end
      pmiu_pkg::FMT_SYMBAND: begin
        st          = (DW'(diff) <= k);
        op_d.mul_a  = b;
        op_d.mul_b  = pmiu_pkg::PROD_W'(k) + pmiu_pkg::PROD_W'(1);
        op_d.addend = pmiu_pkg::OFS_W'(k) - pmiu_pkg::OFS_W'(diff);
        def = 1'b0;
      end
      default: begin
        def = 1'b0;
      end
    endcase

    if (wend || !def) begin
      nr = '0;
      nc = '0;
    end
    if (!def) wend = 1'b0;

    op_d.stored            = st;
    op_d.walk.next_row     = nr[pmiu_pkg::POS_W-1:0];
    op_d.walk.next_col     = nc[pmiu_pkg::POS_W-1:0];
    op_d.walk.walk_end     = wend;
    op_d.walk.walk_defined = def;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q <= op_d;
    end
  end

  assign out_valid_o = valid_q;
  assign op_o        = op_q;

endmodule

[rtl/core/pmiu_mul.sv]
// Stage 2: the one 10 x 22 bit multiply, product kept mod 2^22.
module pmiu_mul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pmiu_pkg::op_t   op_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pmiu_pkg::prod_t prod_o
);

  logic            valid_q;
  pmiu_pkg::prod_t prod_q, prod_d;

  always_comb begin
    prod_d.prod   = pmiu_pkg::PROD_W'(op_i.mul_a) * op_i.mul_b;
    prod_d.half   = op_i.half;
    prod_d.addend = op_i.addend;
    prod_d.stored = op_i.stored;
    prod_d.walk   = op_i.walk;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign out_valid_o = valid_q;
  assign prod_o      = prod_q;

endmodule

[rtl/core/pmiu_fin.sv]
// Stage 3: halve, add the offset term, mask unstored positions; output register.
module pmiu_fin (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pmiu_pkg::prod_t prod_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pmiu_pkg::res_t  res_o
);

  logic                          valid_q;
  pmiu_pkg::res_t                res_q, res_d;
  logic [pmiu_pkg::OFS_W-1:0]    base;

  // triangular forms carry n(n+1) or the lower product, both even
  assign base = prod_i.half ? prod_i.prod[pmiu_pkg::PROD_W-1:1]
                            : prod_i.prod[pmiu_pkg::OFS_W-1:0];

  always_comb begin
    res_d.offset = prod_i.stored ? base + prod_i.addend : '0;
    res_d.stored = prod_i.stored;
    res_d.walk   = prod_i.walk;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[rtl/core/packed_matrix_index_unit.sv]
// Top level of the packed matrix index unit: config registers and 3-stage pipe.
//
//  channel   dir   handshake                       payload
//  -------   ---   -----------------------------   -------------------------------
//  s_axis    in    s_axis_tvalid / s_axis_tready   row_pos, col_pos
//  m_axis    out   m_axis_tvalid / m_axis_tready   offset, stored, walk result
//  cfg       in    cfg_we_i (no wait)              format, sizes, diag counts, walk
//
// One beat in and one beat out per cycle when the sink keeps up; a beat passes
// the decode, multiply and add/output registers in turn. The multiply stage
// sets the cycle: one 10 x 22 bit product between registers.
// Reset clears the stage valid bits and all configuration registers to 0.
// Each stage holds its beat until the next one frees up; ready runs back
// through the stages, so a stalled sink fills the pipe and nothing is lost.
// Storage offsets are column-major and wrap to 21 bits; a diagonal count of
// 1024 means all diagonals. Banded formats report no walk.
module packed_matrix_index_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // [9:0] row_pos, [19:10] col_pos, [23:20] zero
  input  logic [pmiu_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [20:0] offset, [21] stored, [31:22] next_row, [41:32] next_col,
  // [42] walk_end, [43] walk_defined, [47:44] zero
  output logic [pmiu_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_we_i,
  input  logic [pmiu_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [pmiu_pkg::CFG_W-1:0]         cfg_data_i
);

  pmiu_pkg::cfg_t  cfg_q;
  pmiu_pkg::op_t   op;
  pmiu_pkg::prod_t prod;
  pmiu_pkg::res_t  res;
  logic            s1_valid, s1_ready;
  logic            s2_valid, s2_ready;

  // configuration registers; user writes only while the pipe is empty (unchecked)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pmiu_pkg::REG_FORMAT:      cfg_q.format          <= cfg_data_i[pmiu_pkg::FMT_W-1:0];
        pmiu_pkg::REG_TOTAL_ROWS:  cfg_q.total_rows      <= cfg_data_i;
        pmiu_pkg::REG_TOTAL_COLS:  cfg_q.total_cols      <= cfg_data_i;
        pmiu_pkg::REG_SUB_DIAGS:   cfg_q.sub_diags       <= cfg_data_i;
        pmiu_pkg::REG_SUPER_DIAGS: cfg_q.super_diags     <= cfg_data_i;
        pmiu_pkg::REG_TRANSPOSED:  cfg_q.transposed_walk <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pmiu_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .row_pos_i   (s_axis_tdata[9:0]),
    .col_pos_i   (s_axis_tdata[19:10]),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .op_o        (op)
  );

  pmiu_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .op_i        (op),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .prod_o      (prod)
  );

  pmiu_fin u_fin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .prod_i      (prod),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {4'b0, res.walk.walk_defined, res.walk.walk_end,
                         res.walk.next_col, res.walk.next_row,
                         res.stored, res.offset};

`ifndef SYNTHESIS
  // input side only blocks when every stage is full and the sink stalls
  a_full_pipe_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with room in the pipe");

  // unstored positions report a zero offset
  a_unstored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[21]) |-> (m_axis_tdata[20:0] == '0))
    else $error("offset nonzero for unstored position");

  // no walk result where the format has no walk rule, none after the end
  a_walk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (!m_axis_tdata[43] || m_axis_tdata[42]))
      |-> (m_axis_tdata[41:22] == '0))
    else $error("next position nonzero without a walk step");

  // a sink stall at a full pipe holds the output beat in place
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tready && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pipe drained during an output stall");
`endif

endmodule

[test/packed_matrix_index_unit_test.sv]
// Self-checking testbench for packed_matrix_index_unit: directed corners, random walks, stalls.
`timescale 1ns / 1ps

module packed_matrix_index_unit_test;
  import pmiu_pkg::*;

  // format code with no storage rule; every result field reads back 0
  localparam logic [FMT_W-1:0] FMT_UNUSED = 3'd7;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;      // pipe is three stages deep
  localparam int STALL_CYCLES = 80;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    logic [OFS_W-1:0] offset;
    logic             stored;
    logic [POS_W-1:0] next_row;
    logic [POS_W-1:0] next_col;
    logic             walk_end;
    logic             walk_defined;
  } index_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and the signals driven into the unit
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // [9:0] row_pos, [19:10] col_pos, [23:20] zero
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [20:0] offset, [21] stored, [31:22] next_row, [41:32] next_col,
  // [42] walk_end, [43] walk_defined, [47:44] zero
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_we_i   = 1'b0;
  logic [IDX_W-1:0]     cfg_idx_i  = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  packed_matrix_index_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the config registers, expected-result store, counters
  // ---------------------------------------------------------------------------
  logic [FMT_W-1:0] cfg_fmt  = FMT_FULL;
  int               cfg_rows = 0;
  int               cfg_cols = 0;
  int               cfg_sub  = 0;
  int               cfg_sup  = 0;
  bit               cfg_tw   = 1'b0;

  index_result_t pending_offsets[$];
  index_result_t last_walk;          // prediction for the latest beat, used to chain walks

  int error_count   = 0;
  int sent_count    = 0;
  int result_count  = 0;
  int setting_count = 0;
  int cycle_count   = 0;

  // idle odds in percent, written by the tests
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  // long sink hold-off: tests bump stall_req, the ready process counts it out
  int stall_req  = 0;
  int stall_len  = 0;
  int stall_ack  = 0;
  int stall_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // diagonal count of 1024 stands for every diagonal of the matrix
  function automatic longint band_count(input longint rows, input longint d);
    if (d != MAX_DIM) return d;
    return (rows > 0) ? rows - 1 : 0;
  endfunction

  // column-by-column walk over the upper triangle; done once past the last column
  function automatic void upper_step(input longint lim, input longint r_in,
                                     input longint c_in, output longint r_out,
                                     output longint c_out, output bit done);
    longint r;
    longint c;
    r = r_in;
    c = c_in;
    if (r <= c) r++;
    if (r > c) begin
      c++;
      r = 0;
    end
    r_out = r;
    c_out = c;
    done  = (c >= lim);
  endfunction

  function automatic index_result_t predict_index(input logic [POS_W-1:0] row,
                                                  input logic [POS_W-1:0] col);
    longint rr, cc, rows, cols, ofs, nr, nc, kl, ku, k, a, b;
    bit st, fin, def;
    index_result_t res;
    rr = longint'(row);
    cc = longint'(col);
    rows = longint'(cfg_rows);
    cols = longint'(cfg_cols);
    ofs = 0;
    nr = 0;
    nc = 0;
    st = 1'b0;
    fin = 1'b0;
    def = 1'b1;
    a = (rr <= cc) ? rr : cc;
    b = (rr <= cc) ? cc : rr;
    case (cfg_fmt)
      FMT_FULL, FMT_SYM: begin
        if (cfg_fmt == FMT_FULL) ofs = cc * rows + rr;
        else ofs = a + b * (b + 1) / 2;
        st = 1'b1;
        nr = rr;
        nc = cc;
        if (nr < rows) nr++;
        if (nr >= rows) begin
          nr = 0;
          nc++;
        end
        fin = (nc >= cols);
      end
      FMT_BANDED: begin
        kl = band_count(rows, longint'(cfg_sub));
        ku = band_count(rows, longint'(cfg_sup));
        if ((cc <= rr && rr - cc <= kl) || (cc > rr && cc - rr <= ku)) begin
          st = 1'b1;
          ofs = (ku + rr - cc) + cc * (kl + ku + 1);
        end
        def = 1'b0;
      end
      FMT_UPPER: begin
        if (rr <= cc) begin
          st = 1'b1;
          ofs = rr + cc * (cc + 1) / 2;
        end
        upper_step(cols, rr, cc, nr, nc, fin);
      end
      FMT_LOWER: begin
        // signed: the row term goes negative for a column past 2*cols-1
        if (rr >= cc) begin
          st = 1'b1;
          ofs = (2 * cols - cc - 1) * cc / 2 + rr;
        end
        if (cfg_tw) begin
          // upper walk on the mirrored position, coordinates swapped back
          upper_step(rows, cc, rr, nc, nr, fin);
        end else begin
          nr = rr;
          nc = cc;
          if (nr < rows) nr++;
          if (nr >= rows) begin
            nc++;
            nr = nc;
          end
          fin = (nc >= cols);
        end
      end
      FMT_DIAG: begin
        if (rr == cc) begin
          st = 1'b1;
          ofs = rr;
        end
        nr = rr;
        nc = cc;
        if (nr < rows) begin
          nr++;
          nc++;
        end
        fin = (nr >= rows);   // column deliberately not checked
      end
      FMT_SYMBAND: begin
        k = band_count(rows, longint'(cfg_sup));
        if (b - a <= k) begin
          st = 1'b1;
          ofs = (k - (b - a)) + b * (k + 1);
        end
        def = 1'b0;
      end
      default: def = 1'b0;
    endcase
    if (!st) ofs = 0;
    if (fin || !def) begin
      nr = 0;
      nc = 0;
    end
    if (!def) fin = 1'b0;
    res.offset       = ofs[OFS_W-1:0];
    res.stored       = st;
    res.next_row     = nr[POS_W-1:0];
    res.next_col     = nc[POS_W-1:0];
    res.walk_end     = fin;
    res.walk_defined = def;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_REPORTS)
      $display("[%0t] result %0d: %s is %0d, expected %0d", $realtime, result_count,
               what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    index_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_offsets.size() == 0) begin
        report_mismatch("unexpected beat, offset", 32'(m_axis_tdata[20:0]), 0);
      end else begin
        want = pending_offsets.pop_front();
        if (m_axis_tdata[20:0] !== want.offset)
          report_mismatch("offset", 32'(m_axis_tdata[20:0]), 32'(want.offset));
        if (m_axis_tdata[21] !== want.stored)
          report_mismatch("stored", 32'(m_axis_tdata[21]), 32'(want.stored));
        if (m_axis_tdata[31:22] !== want.next_row)
          report_mismatch("next_row", 32'(m_axis_tdata[31:22]), 32'(want.next_row));
        if (m_axis_tdata[41:32] !== want.next_col)
          report_mismatch("next_col", 32'(m_axis_tdata[41:32]), 32'(want.next_col));
        if (m_axis_tdata[42] !== want.walk_end)
          report_mismatch("walk_end", 32'(m_axis_tdata[42]), 32'(want.walk_end));
        if (m_axis_tdata[43] !== want.walk_defined)
          report_mismatch("walk_defined", 32'(m_axis_tdata[43]),
                          32'(want.walk_defined));
      end
      result_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_offsets.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sink ready: random idling, or a counted hold-off when a test asks for one
  always @(posedge clk_i) begin
    if (stall_ack != stall_req) begin
      stall_ack  = stall_req;
      stall_left = stall_len;
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driver tasks
  // ---------------------------------------------------------------------------
  // one beat per call; called at a clock edge, returns at the accepting edge
  task automatic send_pos(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {4'b0, col, row};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    last_walk = predict_index(row, col);
    pending_offsets.push_back(last_walk);
    sent_count++;
  endtask

  // drop valid, wait until every beat is back, then let the pipe settle
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    case (idx)
      REG_FORMAT:      cfg_fmt  = val[FMT_W-1:0];
      REG_TOTAL_ROWS:  cfg_rows = int'(val[CFG_W-1:0]);
      REG_TOTAL_COLS:  cfg_cols = int'(val[CFG_W-1:0]);
      REG_SUB_DIAGS:   cfg_sub  = int'(val[CFG_W-1:0]);
      REG_SUPER_DIAGS: cfg_sup  = int'(val[CFG_W-1:0]);
      REG_TRANSPOSED:  cfg_tw   = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // only called with the pipe drained
  task automatic set_config(input logic [FMT_W-1:0] fmt, input int rows, input int cols,
                            input int sub, input int sup, input int tw);
    write_reg(REG_FORMAT, int'(fmt));
    write_reg(REG_TOTAL_ROWS, rows);
    write_reg(REG_TOTAL_COLS, cols);
    write_reg(REG_SUB_DIAGS, sub);
    write_reg(REG_SUPER_DIAGS, sup);
    write_reg(REG_TRANSPOSED, tw);
    cfg_we_i <= 1'b0;
    last_walk.walk_defined = 1'b0;   // no chaining across settings
    setting_count++;
  endtask

  function automatic int pick_dim();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 1;
      2, 3:    return $urandom_range(2, 24);
      4:       return MAX_DIM;
      default: return $urandom_range(0, MAX_DIM);
    endcase
  endfunction

  function automatic int pick_diags();
    case ($urandom_range(3))
      0:       return 0;
      1:       return MAX_DIM;
      2:       return $urandom_range(1, 6);
      default: return $urandom_range(0, MAX_DIM);
    endcase
  endfunction

  // mostly inside the matrix, sometimes anywhere in the 10-bit range
  function automatic logic [POS_W-1:0] pick_pos(input int lim);
    if (lim > 0 && $urandom_range(99) < 75) return POS_W'($urandom_range(0, lim - 1));
    return POS_W'($urandom_range(0, 1023));
  endfunction

  task automatic random_config();
    logic [FMT_W-1:0] fmt;
    fmt = ($urandom_range(19) == 0) ? FMT_UNUSED : FMT_W'($urandom_range(0, 6));
    set_config(fmt, pick_dim(), pick_dim(), pick_diags(), pick_diags(),
               $urandom_range(0, 1));
  endtask

  // follow the walk most of the time so sequences run into their end
  task automatic send_walk_or_random();
    if (last_walk.walk_defined && !last_walk.walk_end && $urandom_range(99) < 70)
      send_pos(last_walk.next_row, last_walk.next_col);
    else
      send_pos(pick_pos(cfg_rows), pick_pos(cfg_cols));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_corners();
    src_idle_pct  = 7;
    sink_idle_pct = 52;
    // reset values: empty full matrix, walk ends at once
    send_pos(10'd0, 10'd0);
    send_pos(10'd1023, 10'd1023);
    wait_drain();
    set_config(FMT_FULL, MAX_DIM, MAX_DIM, 0, 0, 0);
    send_pos(10'd1023, 10'd1023);
    send_pos(10'd1023, 10'd0);
    wait_drain();
    // all diagonals in both directions
    set_config(FMT_BANDED, MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, 0);
    send_pos(10'd1023, 10'd0);
    send_pos(10'd0, 10'd1023);
    wait_drain();
    set_config(FMT_BANDED, 8, 8, 0, 0, 0);
    send_pos(10'd3, 10'd3);
    send_pos(10'd4, 10'd3);
    wait_drain();
    // upper: last element, and a walk from a position that is not stored
    set_config(FMT_UPPER, MAX_DIM, MAX_DIM, 0, 0, 0);
    send_pos(10'd1023, 10'd1023);
    send_pos(10'd5, 10'd2);
    wait_drain();
    set_config(FMT_LOWER, MAX_DIM, MAX_DIM, 0, 0, 0);
    send_pos(10'd1023, 10'd0);
    send_pos(10'd1023, 10'd1023);
    wait_drain();
    // no columns: row term negative, offset wraps
    set_config(FMT_LOWER, 16, 0, 0, 0, 0);
    send_pos(10'd7, 10'd5);
    wait_drain();
    set_config(FMT_LOWER, 16, 16, 0, 0, 1);
    send_pos(10'd15, 10'd15);
    send_pos(10'd3, 10'd2);
    wait_drain();
    set_config(FMT_SYM, MAX_DIM, MAX_DIM, 0, 0, 0);
    send_pos(10'd1023, 10'd5);
    wait_drain();
    set_config(FMT_DIAG, MAX_DIM, MAX_DIM, 0, 0, 0);
    send_pos(10'd1023, 10'd1023);
    send_pos(10'd3, 10'd7);
    wait_drain();
    set_config(FMT_DIAG, 0, 0, 0, 0, 0);
    send_pos(10'd0, 10'd0);
    wait_drain();
    set_config(FMT_SYMBAND, MAX_DIM, MAX_DIM, 0, MAX_DIM, 0);
    send_pos(10'd0, 10'd1023);
    wait_drain();
    set_config(FMT_SYMBAND, 8, 8, 0, 0, 0);
    send_pos(10'd2, 10'd3);
    wait_drain();
    set_config(FMT_UNUSED, MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, 1);
    send_pos(10'd1, 10'd1);
    wait_drain();
  endtask

  task automatic run_random_phase(input int src_pct, input int sink_pct, input int n_items);
    int left;
    int batch;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    left = n_items;
    while (left > 0) begin
      batch = $urandom_range(20, 60);
      if (batch > left) batch = left;
      wait_drain();
      random_config();
      repeat (batch) send_walk_or_random();
      left -= batch;
    end
    wait_drain();
  endtask

  task automatic test_random_sink_heavy();
    run_random_phase(7, 52, 620);
  endtask

  task automatic test_random_source_heavy();
    run_random_phase(52, 7, 620);
  endtask

  task automatic test_random_no_idle();
    run_random_phase(0, 0, 620);
  endtask

  // sink holds off while the source keeps pushing a full-format walk
  task automatic test_backpressure();
    wait_drain();
    set_config(FMT_FULL, 24, 24, 0, 0, 0);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_len = STALL_CYCLES;
    stall_req++;
    send_pos(10'd0, 10'd0);
    repeat (39) send_pos(last_walk.next_row, last_walk.next_col);
    wait_drain();
  endtask

  initial begin
    last_walk.walk_defined = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_sink_heavy();
    test_random_source_heavy();
    test_random_no_idle();
    test_backpressure();

    $display("Ran %0d positions (%0d results) over %0d register settings: all formats,",
             sent_count, result_count, setting_count);
    $display("the unused code, chained walks, idle mixes and a %0d-cycle sink hold-off.",
             STALL_CYCLES);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
